/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the synchronous reset is active.
`define OAID_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define OAID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/core/oaid_pkg.sv */
// Package for the ordered array insert/delete block: item types, mode and status codes.
// No dependencies.
`default_nettype none

package oaid_pkg;

    localparam int MODE_W = 3;
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 9;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] data;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic [IDX_W-1:0]         found_position;
        logic [CNT_W-1:0]         entry_count;
        logic [CNT_W-1:0]         logical_capacity;
    } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/ordered_array_insert_delete.sv */
// Top level of the ordered array insert/delete block.
// Depends on oaid_pkg, oaid_ctrl and oaid_mem.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    oaid_pkg::in_item_t  (mode, index, data)
//   m_        out        m_valid / m_ready    oaid_pkg::out_item_t (status .. capacity)
//   cfg_      in         cfg_we, no wait      cfg_wdata: initial_capacity
//
// One item at a time; entries sit in a one-read, one-write memory, one walk step a cycle.
// Insert moves the entries from index up one place, delete moves those above index down one
//   place, and find scans from entry 0 up to the first match of the entry at index.
// aresetn (synchronous) clears the count, loads capacity 1 and empties the output
// register; a waiting result stalls only the finish of the next item, not its accept.
`default_nettype none

module ordered_array_insert_delete #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oaid_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output oaid_pkg::out_item_t m_item,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_wdata
);
    import oaid_pkg::*;

    // Address width for the store, count width to hold DEPTH itself.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [31:0]   mem_wr_data;

    // Sequencer: decode, walks, count and capacity, output register.
    oaid_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // Entry store; shift walks read two places ahead of the write, so no
    // read ever hits the entry written in the same cycle.
    oaid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

endmodule

`default_nettype wire

/* rtl/core/oaid_mem.sv */
// Entry store: single write port, single read port, registered read data.
// No package dependencies.
`default_nettype none

module oaid_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem_array [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/oaid_ctrl.sv */
// Sequencer for the ordered array: request decode, shift/scan walks, count and capacity.
// Depends on oaid_pkg; drives the oaid_mem ports.
`default_nettype none

module oaid_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oaid_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output oaid_pkg::out_item_t m_item,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_wdata,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr,
    input  logic [31:0]         mem_rd_data,
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output logic [31:0]         mem_wr_data
);
    import oaid_pkg::*;

    localparam int XW = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_UP        = 4'd2;
    localparam logic [3:0] S_UP_FIN    = 4'd3;
    localparam logic [3:0] S_DN        = 4'd4;
    localparam logic [3:0] S_READ      = 4'd5;
    localparam logic [3:0] S_FIND_TGT  = 4'd6;
    localparam logic [3:0] S_FIND_SCAN = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       cap_reg, cap_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [DATA_W-1:0]   target_reg, target_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_rval_reg, res_rval_next;
    logic [IDX_W-1:0]    res_fpos_reg, res_fpos_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_item_reg, m_item_next;

    logic [XW-1:0]       idx_x, used_x, cfg_x;
    logic [AW-1:0]       idx_a, used_a, last_a;
    logic                bad_ins, bad_acc, need_grow, full;
    logic [CW:0]         cap_dbl;
    logic [CW-1:0]       cap_grown, used_inc, used_dec, cap_half, cap_shrunk;
    logic [CW-1:0]       cfg_clamp, cfg_cap;

    // Index, count and capacity arithmetic.
    always_comb begin
        idx_x     = XW'(idx_reg);
        used_x    = XW'(used_reg);
        idx_a     = AW'(idx_reg);
        used_a    = AW'(used_reg);
        used_inc  = used_reg + CW'(1);
        used_dec  = used_reg - CW'(1);
        last_a    = AW'(used_dec);
        bad_ins   = idx_x > used_x;
        bad_acc   = idx_x >= used_x;
        need_grow = used_reg == cap_reg;
        full      = need_grow && (cap_reg == CW'(DEPTH));
        cap_dbl   = {cap_reg, 1'b0};
        if (!need_grow) begin
            cap_grown = cap_reg;
        end else if (cap_dbl > (CW+1)'(DEPTH)) begin
            cap_grown = CW'(DEPTH);
        end else begin
            cap_grown = cap_dbl[CW-1:0];
        end
        cap_half   = cap_reg >> 1;
        cap_shrunk = ((cap_reg > CW'(1)) && (used_dec <= cap_half)) ? cap_half : cap_reg;
        cfg_x      = XW'(cfg_wdata);
        if (cfg_wdata == 9'd0) begin
            cfg_clamp = CW'(1);
        end else if (cfg_x > XW'(DEPTH)) begin
            cfg_clamp = CW'(DEPTH);
        end else begin
            cfg_clamp = CW'(cfg_wdata);
        end
        cfg_cap = (cfg_clamp < used_reg) ? used_reg : cfg_clamp;
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        data_next       = data_reg;
        used_next       = used_reg;
        cap_next        = cap_reg;
        ptr_next        = ptr_reg;
        target_next     = target_reg;
        res_status_next = res_status_reg;
        res_rval_next   = res_rval_reg;
        res_fpos_next   = res_fpos_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = ptr_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = ptr_reg;
        mem_wr_data     = mem_rd_data;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_item.mode;
                    idx_next   = s_item.index;
                    data_next  = s_item.data;
                    state_next = S_START;
                end
            end
            S_START: begin
                res_status_next = ST_OK;
                res_rval_next   = '0;
                res_fpos_next   = '0;
                state_next      = S_DONE;
                unique case (mode_reg)
                    MODE_APPEND: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = used_a;
                            mem_wr_data = data_reg;
                            used_next   = used_inc;
                            cap_next    = cap_grown;
                        end
                    end
                    MODE_INSERT: begin
                        if (bad_ins) begin
                            res_status_next = ST_BAD_INDEX;
                        end else if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            cap_next = cap_grown;
                            if (idx_x == used_x) begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = idx_a;
                                mem_wr_data = data_reg;
                                used_next   = used_inc;
                            end else begin
                                // Walk down from the last entry, one move per cycle.
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = last_a;
                                ptr_next    = last_a;
                                state_next  = S_UP;
                            end
                        end
                    end
                    MODE_EDIT: begin
                        if (bad_acc) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = idx_a;
                            mem_wr_data = data_reg;
                        end
                    end
                    MODE_DELETE: begin
                        if (bad_acc) begin
                            res_status_next = ST_BAD_INDEX;
                        end else if (idx_x + XW'(1) == used_x) begin
                            used_next = used_dec;
                            cap_next  = cap_shrunk;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_a + AW'(1);
                            ptr_next    = idx_a + AW'(1);
                            state_next  = S_DN;
                        end
                    end
                    MODE_READ: begin
                        if (bad_acc) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_a;
                            state_next  = S_READ;
                        end
                    end
                    MODE_FIND: begin
                        if (bad_acc) begin
                            res_status_next = ST_BAD_INDEX;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = idx_a;
                            state_next  = S_FIND_TGT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UP: begin
                // Move the entry read last cycle one place up.
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg + AW'(1);
                mem_wr_data = mem_rd_data;
                if (ptr_reg == idx_a) begin
                    state_next = S_UP_FIN;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg - AW'(1);
                    ptr_next    = ptr_reg - AW'(1);
                end
            end
            S_UP_FIN: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_a;
                mem_wr_data = data_reg;
                used_next   = used_inc;
                state_next  = S_DONE;
            end
            S_DN: begin
                // Move the entry read last cycle one place down.
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg - AW'(1);
                mem_wr_data = mem_rd_data;
                if (ptr_reg == last_a) begin
                    used_next  = used_dec;
                    cap_next   = cap_shrunk;
                    state_next = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg + AW'(1);
                    ptr_next    = ptr_reg + AW'(1);
                end
            end
            S_READ: begin
                res_rval_next = mem_rd_data;
                state_next    = S_DONE;
            end
            S_FIND_TGT: begin
                target_next = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                ptr_next    = '0;
                state_next  = S_FIND_SCAN;
            end
            S_FIND_SCAN: begin
                // The entry at index matches itself, so the scan always stops.
                if (mem_rd_data == target_reg) begin
                    res_fpos_next = IDX_W'(ptr_reg);
                    state_next    = S_DONE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ptr_reg + AW'(1);
                    ptr_next    = ptr_reg + AW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next.status           = res_status_reg;
                    m_item_next.read_value       = res_rval_reg;
                    m_item_next.found_position   = res_fpos_reg;
                    m_item_next.entry_count      = CNT_W'(used_reg);
                    m_item_next.logical_capacity = CNT_W'(cap_reg);
                    m_valid_next                 = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            cap_next = cfg_cap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            cap_reg     <= CW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        data_reg       <= data_next;
        ptr_reg        <= ptr_next;
        target_reg     <= target_next;
        res_status_reg <= res_status_next;
        res_rval_reg   <= res_rval_next;
        res_fpos_reg   <= res_fpos_next;
        m_item_reg     <= m_item_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

/* rtl/core/oaid_chk.sv */
// Port-level checker for the ordered array block, bound to the top level.
// Depends on oaid_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module oaid_chk (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire oaid_pkg::out_item_t m_item
);
    import oaid_pkg::*;

    `OAID_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready |=> m_valid && $stable(m_item)), "result item changed while stalled")
    `OAID_ASSERT(a_err_zero, aclk, aresetn, (m_valid && m_item.status != ST_OK |-> m_item.read_value == 0 && m_item.found_position == 0), "failed item carries data")
    `OAID_ASSERT(a_full_cnt, aclk, aresetn, (m_valid && m_item.status == ST_FULL |-> m_item.entry_count == m_item.logical_capacity), "full reported below capacity")
    `OAID_ASSERT_ALWAYS(a_rst_empty, aclk, (!aresetn |=> !m_valid), "output valid after reset")

endmodule

bind ordered_array_insert_delete oaid_chk u_oaid_chk (.*);

`default_nettype wire
